>>> rtl/mep_pkg.sv
package mep_pkg;

    // Modulus and its Barrett constant floor(2^60 / P).
    localparam logic [29:0] MODP    = 30'd1000000007;
    localparam logic [30:0] MU      = 31'd1152921496;
    localparam logic [29:0] INV_EXP = 30'd1000000005;

    localparam int EXP_BITS = 31;
    // The inverse needs 30 exponent bits whatever EXP_BITS is.
    localparam int STAGES   = (EXP_BITS > 30) ? EXP_BITS : 30;
    localparam int MUL_LAT  = 4;

    localparam logic OP_POW = 1'b0;
    localparam logic OP_INV = 1'b1;

    typedef logic [29:0]       t_res;
    typedef logic [STAGES-1:0] t_exp;

endpackage

>>> rtl/mep_if.sv
interface mep_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [29:0] base;
    logic [30:0] exponent;
    modport source (output valid, opcode, base, exponent, input ready);
    modport sink   (input valid, opcode, base, exponent, output ready);
endinterface

interface mep_out_if;
    logic        valid;
    logic        ready;
    logic [29:0] result;
    modport source (output valid, result, input ready);
    modport sink   (input valid, result, output ready);
endinterface

>>> rtl/mep_modmul.sv
module mep_modmul (
    input  logic          i_clk,
    input  logic          i_en,
    input  mep_pkg::t_res i_a,
    input  mep_pkg::t_res i_b,
    output mep_pkg::t_res o_p
);
    logic [59:0] r_x1;
    logic [31:0] r_x2;
    logic [61:0] r_t;
    logic [31:0] r_r;
    logic [31:0] r_red;
    logic [30:0] w_q;
    logic [31:0] w_qp;
    logic [31:0] w_fix;

    // Barrett estimate is at most two short, so the remainder stays below 3P.
    assign w_q  = r_t[61:31];
    assign w_qp = {1'b0, w_q} * {2'b00, mep_pkg::MODP};

    always_comb begin
        if (r_r >= {1'b0, mep_pkg::MODP, 1'b0}) begin
            w_fix = r_r - {1'b0, mep_pkg::MODP, 1'b0};
        end else if (r_r >= {2'b00, mep_pkg::MODP}) begin
            w_fix = r_r - {2'b00, mep_pkg::MODP};
        end else begin
            w_fix = r_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x1  <= {30'd0, i_a} * {30'd0, i_b};
            r_t   <= {31'd0, r_x1[59:29]} * {31'd0, mep_pkg::MU};
            r_x2  <= r_x1[31:0];
            r_r   <= r_x2 - w_qp;
            r_red <= w_fix;
        end
    end

    assign o_p = r_red[29:0];
endmodule

>>> rtl/mep_bit_stage.sv
module mep_bit_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  mep_pkg::t_res i_acc,
    input  mep_pkg::t_res i_sq,
    input  mep_pkg::t_exp i_exp,
    output logic          o_valid,
    output mep_pkg::t_res o_acc,
    output mep_pkg::t_res o_sq,
    output mep_pkg::t_exp o_exp
);
    logic          r_v   [mep_pkg::MUL_LAT];
    mep_pkg::t_exp r_e   [mep_pkg::MUL_LAT];
    mep_pkg::t_res w_mul;

    // Multiplying by one when the bit is clear keeps both paths the same length.
    assign w_mul = i_exp[0] ? i_sq : 30'd1;

    mep_modmul u_acc (.i_clk, .i_en, .i_a(i_acc), .i_b(w_mul), .o_p(o_acc));
    mep_modmul u_sq  (.i_clk, .i_en, .i_a(i_sq),  .i_b(i_sq),  .o_p(o_sq));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < mep_pkg::MUL_LAT; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < mep_pkg::MUL_LAT; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e[0] <= i_exp >> 1;
            for (int k = 1; k < mep_pkg::MUL_LAT; k++) r_e[k] <= r_e[k-1];
        end
    end

    assign o_valid = r_v[mep_pkg::MUL_LAT-1];
    assign o_exp   = r_e[mep_pkg::MUL_LAT-1];
endmodule

>>> rtl/modular_exponentiation_prime.sv
// An input register, then one pipeline stage of two modular multipliers
// per exponent bit (mep_bit_stage).
// Throughput: one word per cycle; the whole pipeline holds while a result waits.
// Reset (synchronous, active low) clears all valid bits; data registers are not reset.
module modular_exponentiation_prime (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mep_in_if.sink    i_in,
    mep_out_if.source o_out
);
    logic          w_en;
    logic          w_v   [mep_pkg::STAGES+1];
    mep_pkg::t_res w_acc [mep_pkg::STAGES+1];
    mep_pkg::t_res w_sq  [mep_pkg::STAGES+1];
    mep_pkg::t_exp w_e   [mep_pkg::STAGES+1];
    mep_pkg::t_exp w_in_exp;
    mep_pkg::t_res w_base;

    logic          r_v;
    mep_pkg::t_res r_sq;
    mep_pkg::t_exp r_e;

    assign w_en       = !w_v[mep_pkg::STAGES] || o_out.ready;
    assign i_in.ready = w_en;

    for (genvar g = 0; g < mep_pkg::STAGES; g++) begin : g_mask
        if (g < mep_pkg::EXP_BITS && g < 31) begin : g_use
            assign w_in_exp[g] = i_in.exponent[g];
        end else begin : g_zero
            assign w_in_exp[g] = 1'b0;
        end
    end

    assign w_base = (i_in.base >= mep_pkg::MODP) ? i_in.base - mep_pkg::MODP : i_in.base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_en) begin
            r_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq <= w_base;
            r_e  <= (i_in.opcode == mep_pkg::OP_INV) ?
                    mep_pkg::STAGES'(mep_pkg::INV_EXP) : w_in_exp;
        end
    end

    assign w_v[0]   = r_v;
    assign w_acc[0] = 30'd1;
    assign w_sq[0]  = r_sq;
    assign w_e[0]   = r_e;

    for (genvar s = 0; s < mep_pkg::STAGES; s++) begin : g_stage
        mep_bit_stage u_stage (
            .i_clk,
            .i_rst_n,
            .i_en    (w_en),
            .i_valid (w_v[s]),
            .i_acc   (w_acc[s]),
            .i_sq    (w_sq[s]),
            .i_exp   (w_e[s]),
            .o_valid (w_v[s+1]),
            .o_acc   (w_acc[s+1]),
            .o_sq    (w_sq[s+1]),
            .o_exp   (w_e[s+1])
        );
    end

    assign o_out.valid  = w_v[mep_pkg::STAGES];
    assign o_out.result = w_acc[mep_pkg::STAGES];
endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam logic [63:0] PRIME = 64'd1000000007;
    localparam int LATENCY = 1 + 4 * mep_pkg::STAGES;

    logic i_clk;
    logic i_rst_n;

    mep_in_if  in_ch ();
    mep_out_if out_ch ();

    modular_exponentiation_prime DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    mep_pkg::t_res expected_results[$];
    int   error_count;
    bit   src_idle_en;
    bit   sink_idle_en;
    bit   long_hold;
    int   hold_off_cycles;

    function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b);
        return (a * b) % PRIME;
    endfunction

    function automatic mep_pkg::t_res predict_power(logic opcode, logic [29:0] base,
                                                    logic [30:0] exponent);
        logic [63:0] acc;
        logic [63:0] sq;
        logic [63:0] e;
        acc = 64'd1;
        sq = {34'd0, base} % PRIME;
        if (opcode == mep_pkg::OP_INV) begin
            e = PRIME - 64'd2;
        end else begin
            e = {33'd0, exponent} & ((64'd1 << mep_pkg::EXP_BITS) - 64'd1);
        end
        while (e != 64'd0) begin
            if (e[0]) begin
                acc = mul_mod(acc, sq);
            end
            sq = mul_mod(sq, sq);
            e = e >> 1;
        end
        return acc[29:0];
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR %0t: %s", $time, msg);
        error_count++;
    endtask

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(logic opcode, logic [29:0] base, logic [30:0] exponent);
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.opcode   <= opcode;
        in_ch.base     <= base;
        in_ch.exponent <= exponent;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        expected_results = {expected_results, predict_power(opcode, base, exponent)};
        @(negedge i_clk);
    endtask

    // Sink side: random stalls, plus an occasional long hold-off on request.
    always @(negedge i_clk) begin
        if (long_hold) begin
            long_hold = 1'b0;
            out_ch.ready <= 1'b0;
            hold_off_cycles <= 3 * LATENCY;
        end else if (hold_off_cycles > 0) begin
            out_ch.ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
            out_ch.ready <= 1'b0;
            hold_off_cycles <= $urandom_range(0, 13);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d", out_ch.result));
            end else begin
                mep_pkg::t_res want;
                want = expected_results.pop_front();
                if (out_ch.result !== want) begin
                    report_mismatch($sformatf("result %0d, expected %0d",
                                              out_ch.result, want));
                end
            end
        end
    end

    function automatic logic [29:0] rand_base();
        case ($urandom_range(0, 5))
            0: return 30'd0;
            1: return 30'd1;
            2: return mep_pkg::MODP - 30'd1;
            3: return 30'($urandom_range(32'd1000000007, 32'h3FFFFFFF));
            default: return 30'($urandom_range(0, 32'd1000000006));
        endcase
    endfunction

    function automatic logic [30:0] rand_exponent();
        case ($urandom_range(0, 4))
            0: return 31'($urandom_range(0, 3));
            1: return 31'($urandom_range(0, 1000));
            2: return 31'h7FFFFFFF - 31'($urandom_range(0, 3));
            default: return 31'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        send_word(mep_pkg::OP_POW, 30'd0, 31'd0);
        send_word(mep_pkg::OP_POW, 30'd5, 31'd0);
        send_word(mep_pkg::OP_POW, 30'd0, 31'd1);
        send_word(mep_pkg::OP_POW, 30'd2, 31'd10);
        send_word(mep_pkg::OP_POW, mep_pkg::MODP - 30'd1, 31'h7FFFFFFF);
        send_word(mep_pkg::OP_POW, mep_pkg::MODP - 30'd1, 31'd2);
        send_word(mep_pkg::OP_POW, 30'h3FFFFFFF, 31'h7FFFFFFF);
        send_word(mep_pkg::OP_POW, mep_pkg::MODP, 31'd5);
        send_word(mep_pkg::OP_POW, 30'h2AAAAAAA, 31'h55555555);
        send_word(mep_pkg::OP_POW, 30'h15555555, 31'h2AAAAAAA);
        send_word(mep_pkg::OP_INV, 30'd0, 31'd0);
        send_word(mep_pkg::OP_INV, 30'd1, 31'h7FFFFFFF);
        send_word(mep_pkg::OP_INV, 30'd2, 31'd12345);
        send_word(mep_pkg::OP_INV, mep_pkg::MODP - 30'd1, 31'd0);
        send_word(mep_pkg::OP_INV, 30'h3FFFFFFF, 31'd7);
        send_word(mep_pkg::OP_INV, mep_pkg::MODP, 31'd1);
        send_word(mep_pkg::OP_POW, 30'd3, mep_pkg::MODP - 31'd1);
    endtask

    task automatic test_random(int count);
        repeat (count) begin
            send_word($urandom_range(0, 3) == 0 ? mep_pkg::OP_INV : mep_pkg::OP_POW,
                      rand_base(), rand_exponent());
        end
    endtask

    // The sink stalls long enough that the pipeline fills and the input backs up.
    task automatic test_backpressure();
        long_hold = 1'b1;
        test_random(2 * LATENCY);
    endtask

    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    initial begin
        error_count     = 0;
        src_idle_en     = 1'b0;
        sink_idle_en    = 1'b0;
        long_hold       = 1'b0;
        hold_off_cycles = 0;
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.opcode    = mep_pkg::OP_POW;
        in_ch.base      = '0;
        in_ch.exponent  = '0;
        out_ch.ready    = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        test_random(900);
        test_backpressure();
        test_random(400);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        test_random(150);
        wait_drain();

        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
